@@ design/sha256_pkg.sv @@
// Shared types and constants for the SHA-256 stream hasher.
// Depends on nothing; used by the queue, core and top-level modules.
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [2:0] {
    ST_FILL, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
  } core_state_e;

  localparam logic [7:0] PadMarker = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    round_const = k[i];
  endfunction

endpackage

@@ design/sha256_queue.sv @@
// Front part: accepts and holds input items in a short queue.
// Depends on sha256_pkg.
module sha256_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha256_pkg::item_t  in_item_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output sha256_pkg::item_t  q_item_o
);
  sha256_pkg::item_t mem_q [sha256_pkg::QueueDepth];
  logic [sha256_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [sha256_pkg::QueuePtrW:0]   cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 3'(sha256_pkg::QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

@@ design/sha256_core.sv @@
// Back part: block buffer, padding, 64-round compression and digest output.
// Depends on sha256_pkg.
module sha256_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  sha256_pkg::item_t  q_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);
  sha256_pkg::core_state_e state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [63:0] bits_q;
  logic [63:0] total_q;
  logic        fin_q;    // a finish is in progress
  logic        mark_q;   // padding marker already written
  logic [2:0]  oidx_q;

  // Whether the block just folded was the length-bearing one.
  logic final_blk_q;

  // Length field goes into bytes 56..63 of the block in which the marker
  // leaves room: the marker's block if it landed below 56, else the next one.
  logic pad_len_ok_q;

  logic [31:0] t1, t2, s0, s1, wnew, x, y, cur_w;
  logic [7:0]  pad_byte;
  logic        take;
  logic [7:0]  put_byte;
  logic        put;

  always_comb begin
    x = w_q[1];
    y = w_q[14];
    s0 = sha256_pkg::rotr(x,7) ^ sha256_pkg::rotr(x,18) ^ (x >> 3);
    s1 = sha256_pkg::rotr(y,17) ^ sha256_pkg::rotr(y,19) ^ (y >> 10);
    wnew = s1 + w_q[9] + s0 + w_q[0];
    cur_w = w_q[0];
    t1 = v_q[7] + (sha256_pkg::rotr(v_q[4],6) ^ sha256_pkg::rotr(v_q[4],11)
         ^ sha256_pkg::rotr(v_q[4],25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + sha256_pkg::round_const(rnd_q) + cur_w;
    t2 = (sha256_pkg::rotr(v_q[0],2) ^ sha256_pkg::rotr(v_q[0],13)
         ^ sha256_pkg::rotr(v_q[0],22))
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Byte written at the fill position while padding, before the length field.
  always_comb begin
    if (!mark_q) pad_byte = sha256_pkg::PadMarker;
    else pad_byte = 8'h00;
  end

  assign q_ready_o = (state_q == sha256_pkg::ST_FILL);
  assign take = q_valid_i && q_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256_pkg::ST_FILL:  if (take) begin
        if (q_item_i.kind) state_d = sha256_pkg::ST_PAD;
        else if (fill_q == 6'd63) state_d = sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_PAD: begin
        // length bytes occupy 56..63 only on the final block
        if (fill_q == 6'd63) state_d = sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_LOAD:  state_d = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha256_pkg::ST_FOLD;
      sha256_pkg::ST_FOLD: begin
        if (!fin_q) state_d = sha256_pkg::ST_FILL;
        else if (final_blk_q) state_d = sha256_pkg::ST_EMIT;
        else state_d = sha256_pkg::ST_PAD;
      end
      sha256_pkg::ST_EMIT:
        if (out_ready_i && oidx_q == 3'd7) state_d = sha256_pkg::ST_FILL;
      default: state_d = sha256_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_FILL;
      fill_q <= '0; rnd_q <= '0; bits_q <= '0; fin_q <= 1'b0; mark_q <= 1'b0;
      oidx_q <= '0; final_blk_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_hash(3'(i));
    end else begin
      state_q <= state_d;
      unique case (state_q)
        sha256_pkg::ST_FILL: if (take) begin
          if (q_item_i.kind) begin
            fin_q <= 1'b1;
            mark_q <= 1'b0;
            final_blk_q <= 1'b0;
          end else begin
            fill_q <= fill_q + 6'd1;
            if (fill_q == 6'd63) bits_q <= bits_q + 64'd512;
          end
        end
        sha256_pkg::ST_PAD: begin
          mark_q <= 1'b1;
          fill_q <= fill_q + 6'd1;
          if (fill_q == 6'd63) final_blk_q <= pad_len_ok_q;
        end
        sha256_pkg::ST_LOAD: begin
          rnd_q <= '0;
        end
        sha256_pkg::ST_ROUND: rnd_q <= rnd_q + 6'd1;
        sha256_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (fin_q && final_blk_q) begin
            oidx_q <= '0;
          end
        end
        sha256_pkg::ST_EMIT: if (out_ready_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            fin_q <= 1'b0; fill_q <= '0; bits_q <= '0;
            for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_hash(3'(i));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_len_ok_q <= 1'b0;
    else if (take && q_item_i.kind) pad_len_ok_q <= (fill_q < 6'd56);
    else if (state_q == sha256_pkg::ST_FOLD) pad_len_ok_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (take && q_item_i.kind) total_q <= bits_q + {55'b0, fill_q, 3'b000};
  end

  // Message words: bytes shift into the word at the fill position; during
  // rounds the sixteen-word window slides by one each cycle.
  always_comb begin
    put = 1'b0;
    put_byte = q_item_i.data_byte;
    if (state_q == sha256_pkg::ST_FILL && take && !q_item_i.kind) put = 1'b1;
    if (state_q == sha256_pkg::ST_PAD) begin
      put = 1'b1;
      put_byte = (mark_q && pad_len_ok_q && fill_q >= 6'd56)
                 ? total_q[8*(6'd63 - fill_q) +: 8] : pad_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], put_byte};
    else if (state_q == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
    if (state_q == sha256_pkg::ST_LOAD)
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    else if (state_q == sha256_pkg::ST_ROUND) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  assign out_valid_o   = (state_q == sha256_pkg::ST_EMIT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);
endmodule

@@ design/sha256_stream_hasher.sv @@
// SHA-256 stream hasher: message bytes fill a block, which is then compressed
// by load, 64 rounds and fold. A finish pads byte by byte, takes one or
// two compressions, then shows eight digest words one per accepted cycle.
// A four-entry queue accepts bytes while a block is compressed.
// Reset (rst_ni, asynchronous, active low) restores the initial hash values,
// a zero count and empty queue.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  sha256_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  assign in_item = '{kind: kind_i, data_byte: data_byte_i};

  sha256_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sha256_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o, .last_word_o
  );
endmodule

@@ design/sha256_checker.sv @@
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends only on the top level's ports.
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  word_index_o,
  input logic        last_word_o,
  input logic [31:0] digest_word_o
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word disagrees with word_index");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
    (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words not consecutive");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled digest word changed");
endmodule

bind sha256_stream_hasher sha256_checker u_checker (.*);
